// ===== sv/gop_pkg.sv =====
package gop_pkg;

    localparam int SAMPLES_DEFAULT = 10;

    localparam int RATE_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int ROUND_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int NSTG    = 7;
    localparam int PROD_W  = 32;
    localparam int DIFF_W  = 17;
    localparam int DPROD_W = 33;
    localparam int D10_W   = 37;
    localparam int ACC_W   = 48;
    localparam int TOT_W   = 50;
    localparam int QTR_W   = 8;

    // exact truncating divide by ten of a 31-bit magnitude
    localparam int          IMAG_W      = 31;
    localparam int          IQ_W        = 28;
    localparam int          DIV10_SHIFT = 35;
    localparam int          DIV10_W     = 32;
    localparam logic [DIV10_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;

    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd256;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;
    localparam logic [ROUND_W-1:0]       ROUND_TOT_RST  = 8'd50;

    localparam logic signed [RATE_W-1:0] OFFSET_MAX = 16'sh7FFF;
    localparam logic signed [RATE_W-1:0] OFFSET_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN,
        CFG_INTEG_GAIN,
        CFG_DERIV_GAIN,
        CFG_ROUND_TOTAL
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop;
        logic signed [GAIN_W-1:0] integ;
        logic signed [GAIN_W-1:0] deriv;
    } t_gains;

    typedef struct packed {
        logic            clear;
        logic            accum;
        logic            round_done;
        logic [NSTG-1:0] load;
        logic [NSTG-1:0] rst_in;
        logic            rst_out;
        logic            tail_valid;
        logic            tail_last;
    } t_pipe_ctl;

endpackage

// ===== sv/gop_ctrl.sv =====
module gop_ctrl
    import gop_pkg::*;
#(
    parameter int SAMPLES_PER_ROUND = SAMPLES_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_op,
    input  logic [ROUND_W-1:0] i_round_total,
    input  logic               i_out_en,
    output logic               o_in_stall,
    output t_pipe_ctl          o_ctl
);

    localparam int CW = (SAMPLES_PER_ROUND > 1) ? $clog2(SAMPLES_PER_ROUND) : 1;
    localparam logic [CW-1:0] CntLast = CW'(SAMPLES_PER_ROUND - 1);

    logic               r_running;
    logic [CW-1:0]      r_count;
    logic [ROUND_W-1:0] r_rounds;
    logic [NSTG-1:0]    r_vld;
    logic [NSTG-1:0]    r_rst;
    logic [NSTG-1:0]    r_lst;

    logic [NSTG-1:0]    en;
    logic               accept;
    logic               is_restart;
    logic               is_sample;
    logic               round_done;
    logic               new_tok;
    logic [ROUND_W-1:0] rounds_inc;
    logic               is_last;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_out_en;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign accept     = i_in_valid && en[0];
    assign o_in_stall = !en[0];
    assign is_restart = accept && i_op;
    assign is_sample  = accept && !i_op && r_running;
    assign round_done = is_sample && (r_count == CntLast);
    assign new_tok    = is_restart || round_done;
    assign rounds_inc = r_rounds + 1'b1;
    assign is_last    = (rounds_inc >= i_round_total);

    always_comb begin
        o_ctl.clear      = is_restart;
        o_ctl.accum      = is_sample;
        o_ctl.round_done = round_done;
        o_ctl.load[0]    = new_tok;
        o_ctl.rst_in[0]  = i_op;
        for (int k = 1; k < NSTG; k++) begin
            o_ctl.load[k]   = en[k] && r_vld[k-1];
            o_ctl.rst_in[k] = r_rst[k-1];
        end
        o_ctl.rst_out    = r_rst[NSTG-1];
        o_ctl.tail_valid = r_vld[NSTG-1];
        o_ctl.tail_last  = r_lst[NSTG-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b1;
            r_count   <= '0;
            r_rounds  <= '0;
        end else if (is_restart) begin
            r_running <= 1'b1;
            r_count   <= '0;
            r_rounds  <= '0;
        end else if (round_done) begin
            r_count  <= '0;
            r_rounds <= rounds_inc;
            if (is_last) begin
                r_running <= 1'b0;
            end
        end else if (is_sample) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= new_tok;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (new_tok) begin
            r_rst[0] <= i_op;
            r_lst[0] <= !i_op && is_last;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (o_ctl.load[k]) begin
                r_rst[k] <= r_rst[k-1];
                r_lst[k] <= r_lst[k-1];
            end
        end
    end

endmodule

// ===== sv/gop_lane.sv =====
module gop_lane
    import gop_pkg::*;
#(
    parameter int SAMPLES_PER_ROUND = SAMPLES_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pipe_ctl                i_ctl,
    input  t_gains                   i_gains,
    input  logic signed [RATE_W-1:0] i_rate,
    output logic signed [RATE_W-1:0] o_offset
);

    localparam int LG  = $clog2(SAMPLES_PER_ROUND);
    localparam int SW  = RATE_W + 1 + LG;
    localparam int QW  = SW - LG + 1;
    localparam int RSH = SW + LG;
    localparam int RW  = SW + 2;
    localparam longint unsigned RecipL =
        ((64'd1 << RSH) + 64'(SAMPLES_PER_ROUND) - 64'd1) / 64'(SAMPLES_PER_ROUND);
    localparam logic [RW-1:0] Recip = RW'(RecipL);

    // stage 0: running sum
    logic signed [SW-1:0]      r_sum;
    logic signed [SW-1:0]      r0_sum;
    logic signed [SW-1:0]      sum_nx;
    // stage 1: quotient magnitude
    logic [SW-1:0]             mag_c;
    logic [SW+RW-1:0]          qprod_c;
    logic [QW-1:0]             r1_q;
    logic                      r1_neg;
    // stage 2: average and difference
    logic signed [RATE_W-1:0]  avg_c;
    logic signed [DIFF_W-1:0]  diff_c;
    logic signed [RATE_W-1:0]  r_prev;
    logic signed [RATE_W-1:0]  r2_avg;
    logic signed [DIFF_W-1:0]  r2_diff;
    // stage 3: products
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic signed [PROD_W-1:0]  p_c;
    logic signed [PROD_W-1:0]  i_c;
    logic signed [DPROD_W-1:0] d_c;
    logic signed [PROD_W-1:0]  r3_p;
    logic signed [PROD_W-1:0]  r3_i;
    logic signed [DPROD_W-1:0] r3_d;
    // stage 4: integral step over ten, derivative times ten
    logic [PROD_W-1:0]         iabs_c;
    logic [IMAG_W-1:0]         imag_c;
    logic [IMAG_W+DIV10_W-1:0] iprod_c;
    logic signed [D10_W-1:0]   dext_c;
    logic signed [D10_W-1:0]   d10_c;
    logic signed [PROD_W-1:0]  r4_p;
    logic [IQ_W-1:0]           r4_iq;
    logic                      r4_ineg;
    logic signed [D10_W-1:0]   r4_d10;
    // stage 5: integral accumulator
    logic signed [ACC_W-1:0]   iv_c;
    logic signed [ACC_W-1:0]   idiv_c;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r5_p;
    logic signed [D10_W-1:0]   r5_d10;
    // stage 6: pid sum
    logic signed [TOT_W-1:0]   tot_c;
    logic signed [TOT_W-1:0]   r6_total;
    // tail: scale and saturate
    logic signed [TOT_W-1:0]   biased_c;
    logic signed [TOT_W-1:0]   scaled_c;
    logic signed [RATE_W-1:0]  sat_c;

    assign sum_nx = r_sum + SW'(i_rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear || i_ctl.round_done) begin
            r_sum <= '0;
        end else if (i_ctl.accum) begin
            r_sum <= sum_nx;
        end
        if (i_ctl.load[0]) begin
            r0_sum <= sum_nx;
        end
    end

    assign mag_c   = r0_sum[SW-1] ? SW'(-r0_sum) : SW'(r0_sum);
    assign qprod_c = (SW+RW)'(mag_c) * (SW+RW)'(Recip);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r1_q   <= qprod_c[RSH +: QW];
            r1_neg <= r0_sum[SW-1];
        end
    end

    // average is the negated mean
    always_comb begin
        if (r1_neg) begin
            avg_c = (r1_q > QW'(32767)) ? OFFSET_MAX : signed'(r1_q[RATE_W-1:0]);
        end else begin
            avg_c = (r1_q > QW'(32768)) ? OFFSET_MIN : signed'(RATE_W'(-r1_q[RATE_W-1:0]));
        end
    end

    assign diff_c = DIFF_W'(avg_c) - DIFF_W'(r_prev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_ctl.load[2]) begin
            r_prev <= i_ctl.rst_in[2] ? '0 : avg_c;
        end
        if (i_ctl.load[2]) begin
            r2_avg  <= avg_c;
            r2_diff <= diff_c;
        end
    end

    assign kp  = i_gains.prop;
    assign ki  = i_gains.integ;
    assign kd  = i_gains.deriv;
    assign p_c = PROD_W'(r2_avg) * PROD_W'(kp);
    assign i_c = PROD_W'(r2_avg) * PROD_W'(ki);
    assign d_c = DPROD_W'(r2_diff) * DPROD_W'(kd);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r3_p <= p_c;
            r3_i <= i_c;
            r3_d <= d_c;
        end
    end

    assign iabs_c  = r3_i[PROD_W-1] ? PROD_W'(-r3_i) : PROD_W'(r3_i);
    assign imag_c  = iabs_c[IMAG_W-1:0];
    assign iprod_c = (IMAG_W+DIV10_W)'(imag_c) * (IMAG_W+DIV10_W)'(DIV10_RECIP);
    assign dext_c  = D10_W'(r3_d);
    assign d10_c   = (dext_c <<< 3) + (dext_c <<< 1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r4_p    <= r3_p;
            r4_iq   <= iprod_c[DIV10_SHIFT +: IQ_W];
            r4_ineg <= r3_i[PROD_W-1];
            r4_d10  <= d10_c;
        end
    end

    assign iv_c   = signed'(ACC_W'(r4_iq));
    assign idiv_c = r4_ineg ? -iv_c : iv_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.load[5]) begin
            r_acc <= i_ctl.rst_in[5] ? '0 : (r_acc + idiv_c);
        end
        if (i_ctl.load[5]) begin
            r5_p   <= r4_p;
            r5_d10 <= r4_d10;
        end
    end

    assign tot_c = TOT_W'(r5_p) + TOT_W'(r_acc) + TOT_W'(r5_d10);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            r6_total <= tot_c;
        end
    end

    // divide by 256 toward zero
    assign biased_c = r6_total + (r6_total[TOT_W-1] ? TOT_W'(255) : TOT_W'(0));
    assign scaled_c = biased_c >>> QTR_W;

    always_comb begin
        if (scaled_c > TOT_W'(OFFSET_MAX)) begin
            sat_c = OFFSET_MAX;
        end else if (scaled_c < TOT_W'(OFFSET_MIN)) begin
            sat_c = OFFSET_MIN;
        end else begin
            sat_c = scaled_c[RATE_W-1:0];
        end
    end

    assign o_offset = i_ctl.rst_out ? '0 : sat_c;

endmodule

// ===== sv/gyro_offset_pid_calibrator.sv =====
// channel   dir  handshake                 payload
// in        in   i_in_valid / o_in_stall   i_op, i_rate_x, i_rate_y, i_rate_z
// out       out  o_out_valid / i_out_stall o_offset_x/y/z, o_final_round
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle while o_in_stall is low; a round-closing sample or a restart
// gives its result through stage 0, which loads at the transfer, six more lane
// stages, then the output register
// three axis lanes run side by side, the output register merges them
// synchronous active-low reset clears counters, sums, integrals and valids
// an output stall fills the pipeline bubbles first, then stalls the input
module gyro_offset_pid_calibrator
    import gop_pkg::*;
#(
    parameter int SAMPLES_PER_ROUND = SAMPLES_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic signed [RATE_W-1:0]    i_rate_x,
    input  logic signed [RATE_W-1:0]    i_rate_y,
    input  logic signed [RATE_W-1:0]    i_rate_z,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [RATE_W-1:0]    o_offset_x,
    output logic signed [RATE_W-1:0]    o_offset_y,
    output logic signed [RATE_W-1:0]    o_offset_z,
    output logic                        o_final_round,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data
);

    t_gains                   r_gains;
    logic [ROUND_W-1:0]       r_round_total;
    t_pipe_ctl                ctl;
    logic                     out_en;
    logic signed [RATE_W-1:0] off_x;
    logic signed [RATE_W-1:0] off_y;
    logic signed [RATE_W-1:0] off_z;
    logic                     r_out_valid;
    logic signed [RATE_W-1:0] r_offset_x;
    logic signed [RATE_W-1:0] r_offset_y;
    logic signed [RATE_W-1:0] r_offset_z;
    logic                     r_final;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop  <= PROP_GAIN_RST;
            r_gains.integ <= INTEG_GAIN_RST;
            r_gains.deriv <= DERIV_GAIN_RST;
            r_round_total <= ROUND_TOT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:   r_gains.prop  <= signed'(i_cfg_data[GAIN_W-1:0]);
                CFG_INTEG_GAIN:  r_gains.integ <= signed'(i_cfg_data[GAIN_W-1:0]);
                CFG_DERIV_GAIN:  r_gains.deriv <= signed'(i_cfg_data[GAIN_W-1:0]);
                CFG_ROUND_TOTAL: r_round_total <= i_cfg_data[ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_en = !r_out_valid || !i_out_stall;

    gop_ctrl #(
        .SAMPLES_PER_ROUND(SAMPLES_PER_ROUND)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_op          (i_op),
        .i_round_total (r_round_total),
        .i_out_en      (out_en),
        .o_in_stall    (o_in_stall),
        .o_ctl         (ctl)
    );

    gop_lane #(
        .SAMPLES_PER_ROUND(SAMPLES_PER_ROUND)
    ) u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_gains  (r_gains),
        .i_rate   (i_rate_x),
        .o_offset (off_x)
    );

    gop_lane #(
        .SAMPLES_PER_ROUND(SAMPLES_PER_ROUND)
    ) u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_gains  (r_gains),
        .i_rate   (i_rate_y),
        .o_offset (off_y)
    );

    gop_lane #(
        .SAMPLES_PER_ROUND(SAMPLES_PER_ROUND)
    ) u_lane_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_gains  (r_gains),
        .i_rate   (i_rate_z),
        .o_offset (off_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= ctl.tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && ctl.tail_valid) begin
            r_offset_x <= off_x;
            r_offset_y <= off_y;
            r_offset_z <= off_z;
            r_final    <= ctl.tail_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_offset_x    = r_offset_x;
    assign o_offset_y    = r_offset_y;
    assign o_offset_z    = r_offset_z;
    assign o_final_round = r_final;

endmodule

// ===== sv/gop_checker.sv =====
module gop_checker
    import gop_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [RATE_W-1:0] o_offset_x,
    input logic signed [RATE_W-1:0] o_offset_y,
    input logic signed [RATE_W-1:0] o_offset_z,
    input logic                     o_final_round
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // input backs up only behind a held, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with free output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_offset_x) && $stable(o_offset_y) && $stable(o_offset_z)
             && $stable(o_final_round)))
        else $error("stalled result changed");

endmodule

bind gyro_offset_pid_calibrator gop_checker u_gop_checker (.*);

// ===== tb/gyro_offset_pid_calibrator_tb.sv =====
`timescale 1ns / 100ps

module gyro_offset_pid_calibrator_tb;
    import gop_pkg::*;

    localparam int ROUND_LEN   = SAMPLES_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 16;
    localparam int ITEM_GOAL   = 2000;

    typedef struct {
        logic signed [RATE_W-1:0] x;
        logic signed [RATE_W-1:0] y;
        logic signed [RATE_W-1:0] z;
        logic                     last;
    } t_offsets;

    typedef enum int {
        STYLE_BIAS,
        STYLE_EXTREME,
        STYLE_FULL
    } t_stim_style;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_op = 1'b0;
    logic signed [RATE_W-1:0] i_rate_x = '0;
    logic signed [RATE_W-1:0] i_rate_y = '0;
    logic signed [RATE_W-1:0] i_rate_z = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [RATE_W-1:0] o_offset_x;
    logic signed [RATE_W-1:0] o_offset_y;
    logic signed [RATE_W-1:0] o_offset_z;
    logic                     o_final_round;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]     i_cfg_data = '0;

    // calibrator state as predicted
    longint             kp_q88;
    longint             ki_q88;
    longint             kd_q88;
    logic [ROUND_W-1:0] rounds_per_run;
    logic               run_active;
    int                 samples_taken;
    logic [ROUND_W-1:0] rounds_closed;
    longint             rate_sum [3];
    longint             integ_q8 [3];
    longint             prev_avg [3];

    t_offsets pending_offsets [$];
    t_offsets oldest_offsets;

    int  error_count = 0;
    int  results_seen = 0;
    int  finals_seen = 0;
    int  items_in = 0;
    int  ignored_in = 0;
    int  cfg_writes = 0;
    int  cycle_count = 0;
    bit  steady_in = 1'b0;
    bit  steady_out = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;
    int  hold_count = 0;
    int  stall_left = 0;
    int  free_left = 0;

    gyro_offset_pid_calibrator #(
        .SAMPLES_PER_ROUND(ROUND_LEN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_rate_x(i_rate_x),
        .i_rate_y(i_rate_y),
        .i_rate_z(i_rate_z),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_offset_x(o_offset_x),
        .o_offset_y(o_offset_y),
        .o_offset_z(o_offset_z),
        .o_final_round(o_final_round),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_int16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void clear_calibration();
        run_active = 1'b1;
        samples_taken = 0;
        rounds_closed = '0;
        for (int a = 0; a < 3; a++) begin
            rate_sum[a] = 0;
            integ_q8[a] = 0;
            prev_avg[a] = 0;
        end
    endfunction

    function automatic bit track_calibration(input logic op,
                                             input logic signed [RATE_W-1:0] rx,
                                             input logic signed [RATE_W-1:0] ry,
                                             input logic signed [RATE_W-1:0] rz,
                                             output t_offsets res);
        longint                   sample [3];
        longint                   avg;
        longint                   p_term;
        longint                   d_term;
        logic signed [RATE_W-1:0] off [3];
        res.x = '0;
        res.y = '0;
        res.z = '0;
        res.last = 1'b0;
        if (op) begin
            clear_calibration();
            return 1'b1;
        end
        if (!run_active) return 1'b0;
        sample[0] = longint'(rx);
        sample[1] = longint'(ry);
        sample[2] = longint'(rz);
        for (int a = 0; a < 3; a++) rate_sum[a] += sample[a];
        samples_taken++;
        if (samples_taken < ROUND_LEN) return 1'b0;
        for (int a = 0; a < 3; a++) begin
            avg = clamp_int16(-(rate_sum[a] / ROUND_LEN));
            p_term = avg * kp_q88;
            d_term = kd_q88 * (avg - prev_avg[a]) * 10;
            integ_q8[a] += (avg * ki_q88) / 10;
            off[a] = RATE_W'(clamp_int16((p_term + integ_q8[a] + d_term) / 256));
            prev_avg[a] = avg;
            rate_sum[a] = 0;
        end
        samples_taken = 0;
        rounds_closed = rounds_closed + 1'b1;
        res.x = off[0];
        res.y = off[1];
        res.z = off[2];
        res.last = (rounds_closed >= rounds_per_run);
        if (res.last) run_active = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [RATE_W-1:0] any_rate();
        return RATE_W'($urandom);
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_rate(input t_stim_style style,
                                                           input int bias);
        int v;
        case (style)
            STYLE_BIAS: v = bias + int'($urandom_range(0, 100)) - 50;
            STYLE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v[RATE_W-1:0];
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_gain();
        int v;
        case ($urandom_range(0, 9))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            3, 4, 5: v = int'($urandom_range(0, 1024)) - 512;
            default: v = $urandom;
        endcase
        return v[CFG_DAT_W-1:0];
    endfunction

    function automatic logic [ROUND_W-1:0] pick_round_total();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 8'd1;
            2: return 8'd255;
            3: return ROUND_W'($urandom_range(1, 255));
            default: return ROUND_W'($urandom_range(2, 5));
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_in) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic op,
                             input logic signed [RATE_W-1:0] rx,
                             input logic signed [RATE_W-1:0] ry,
                             input logic signed [RATE_W-1:0] rz);
        t_offsets predicted;
        int       gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_rate_x <= rx;
        i_rate_y <= ry;
        i_rate_z <= rz;
        do @(posedge i_clk); while (o_in_stall);
        items_in++;
        if (!op && !run_active) ignored_in++;
        if (track_calibration(op, rx, ry, rz, predicted)) pending_offsets.push_back(predicted);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PROP_GAIN: kp_q88 = longint'($signed(value));
            CFG_INTEG_GAIN: ki_q88 = longint'($signed(value));
            CFG_DERIV_GAIN: kd_q88 = longint'($signed(value));
            CFG_ROUND_TOTAL: rounds_per_run = value[ROUND_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // every pending result out, then room for a round still in flight
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_restart_and_overflow();
        send_item(1'b1, 16'sh7FFF, 16'sh8000, -16'sd1);
        for (int n = 0; n < ROUND_LEN; n++)
            send_item(1'b0, OFFSET_MIN, OFFSET_MAX, (n % 2) ? OFFSET_MAX : OFFSET_MIN);
    endtask

    // round total dropped to zero mid-run, so the next round ends it
    task automatic test_register_extremes();
        wait_idle();
        write_register(CFG_PROP_GAIN, 16'h8000);
        write_register(CFG_INTEG_GAIN, 16'h7FFF);
        write_register(CFG_DERIV_GAIN, 16'h8000);
        write_register(CFG_ROUND_TOTAL, 16'hFF00);
        for (int n = 0; n < ROUND_LEN; n++)
            send_item(1'b0, (n < 5) ? OFFSET_MAX : OFFSET_MIN, any_rate(),
                      (n % 2) ? 16'sd1 : -16'sd1);
        send_item(1'b0, any_rate(), any_rate(), any_rate());
        send_item(1'b0, OFFSET_MIN, OFFSET_MIN, OFFSET_MIN);
        send_item(1'b1, 16'sh0000, 16'sh0000, 16'sh0000);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        steady_in = 1'b1;
        long_hold_req = 1'b1;
        for (int k = 0; k < 40; k++) send_item(1'b1, any_rate(), any_rate(), any_rate());
        for (int k = 0; k < 2 * ROUND_LEN; k++)
            send_item(1'b0, any_rate(), any_rate(), any_rate());
        wait (long_hold_done);
        long_hold_req = 1'b0;
        steady_in = 1'b0;
    endtask

    task automatic test_random_runs();
        int                       useful;
        int                       phase_len;
        int                       bias [3];
        t_stim_style              style;
        logic signed [RATE_W-1:0] rates [3];
        useful = 0;
        while (useful < ITEM_GOAL) begin
            wait_idle();
            steady_in = ($urandom_range(0, 4) == 0);
            steady_out = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) != 0) write_register(CFG_PROP_GAIN, pick_gain());
            if ($urandom_range(0, 2) != 0) write_register(CFG_INTEG_GAIN, pick_gain());
            if ($urandom_range(0, 2) != 0) write_register(CFG_DERIV_GAIN, pick_gain());
            if ($urandom_range(0, 2) != 0)
                write_register(CFG_ROUND_TOTAL, {8'($urandom), pick_round_total()});
            style = t_stim_style'($urandom_range(0, 2));
            for (int a = 0; a < 3; a++) bias[a] = int'($urandom_range(0, 4000)) - 2000;
            if ($urandom_range(0, 1) != 0) begin
                send_item(1'b1, any_rate(), any_rate(), any_rate());
                useful++;
            end
            phase_len = $urandom_range(40, 250);
            for (int k = 0; k < phase_len; k++) begin
                if (!run_active) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_item(1'b0, any_rate(), any_rate(), any_rate());
                    end else begin
                        send_item(1'b1, any_rate(), any_rate(), any_rate());
                        useful++;
                    end
                end else if ($urandom_range(0, 79) == 0) begin
                    send_item(1'b1, any_rate(), any_rate(), any_rate());
                    useful++;
                end else begin
                    for (int a = 0; a < 3; a++) rates[a] = pick_rate(style, bias[a]);
                    send_item(1'b0, rates[0], rates[1], rates[2]);
                    useful++;
                end
            end
        end
        steady_in = 1'b0;
        steady_out = 1'b0;
    endtask

    // receiver side: random stall runs, one long hold on request
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            i_out_stall <= 1'b1;
            hold_count++;
            if (hold_count >= LONG_HOLD) long_hold_done = 1'b1;
        end else if (steady_out || long_hold_req) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            i_out_stall <= 1'b0;
            free_left--;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40);
            free_left = $urandom_range(0, 12);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_offsets.size() == 0) begin
                $error("unexpected result: offset_x %0d offset_y %0d offset_z %0d final %0b",
                       o_offset_x, o_offset_y, o_offset_z, o_final_round);
                error_count++;
            end else begin
                oldest_offsets = pending_offsets.pop_front();
                results_seen++;
                if (oldest_offsets.last) finals_seen++;
                if (o_offset_x !== oldest_offsets.x) begin
                    $error("offset_x: expected %0d, got %0d", oldest_offsets.x, o_offset_x);
                    error_count++;
                end
                if (o_offset_y !== oldest_offsets.y) begin
                    $error("offset_y: expected %0d, got %0d", oldest_offsets.y, o_offset_y);
                    error_count++;
                end
                if (o_offset_z !== oldest_offsets.z) begin
                    $error("offset_z: expected %0d, got %0d", oldest_offsets.z, o_offset_z);
                    error_count++;
                end
                if (o_final_round !== oldest_offsets.last) begin
                    $error("final_round: expected %0b, got %0b", oldest_offsets.last,
                           o_final_round);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        kp_q88 = longint'(PROP_GAIN_RST);
        ki_q88 = longint'(INTEG_GAIN_RST);
        kd_q88 = longint'(DERIV_GAIN_RST);
        rounds_per_run = ROUND_TOT_RST;
        clear_calibration();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_restart_and_overflow();
        test_register_extremes();
        test_output_backpressure();
        test_random_runs();

        wait_idle();
        $display("%0d input transfers (%0d ignored after a run), %0d register writes",
                 items_in, ignored_in, cfg_writes);
        $display("%0d offset results checked, %0d of them closing a calibration run",
                 results_seen, finals_seen);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
